// File: rtl/sct_pkg.sv
// sct_pkg: shared types, constants and character class functions for the
// source character tokenizer. No dependencies.
package sct_pkg;

    localparam int MAX_TOKEN_LEN = 255;
    localparam int LEN_CAP       = (MAX_TOKEN_LEN > 255) ? 255 : MAX_TOKEN_LEN;

    localparam int CHAR_W      = 8;
    localparam int POS_W       = 24;
    localparam int LEN_W       = 8;
    localparam int LINE_W      = 20;
    localparam int KIND_W      = 3;
    localparam int MAX_RESULTS = 3;
    localparam int RES_IDX_W   = 2;
    localparam int GROUP_DEPTH = 2;
    localparam int FILL_W      = 2;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 64;

    localparam logic [POS_W-1:0]  POS_MAX  = '1;
    localparam logic [LINE_W-1:0] LINE_MAX = '1;

    localparam logic [CHAR_W-1:0] CHAR_NUL        = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB        = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF         = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_VT         = 8'h0B;
    localparam logic [CHAR_W-1:0] CHAR_FF         = 8'h0C;
    localparam logic [CHAR_W-1:0] CHAR_CR         = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CHAR_DOT        = 8'h2E;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_INT,
        MODE_DOT,
        MODE_FRAC
    } scan_mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_WORD  = 3'd0,
        KIND_INT   = 3'd1,
        KIND_FRAC  = 3'd2,
        KIND_OP    = 3'd3,
        KIND_PUNCT = 3'd4,
        KIND_BAD   = 3'd5
    } token_kind_t;

    // kind sits in the lowest bits
    typedef struct packed {
        logic [LINE_W-1:0] line_number;
        logic [CHAR_W-1:0] first_char;
        logic [LEN_W-1:0]  token_length;
        logic [POS_W-1:0]  token_start;
        token_kind_t       token_kind;
    } token_t;

    typedef struct packed {
        logic [RES_IDX_W-1:0]       count;
        token_t [MAX_RESULTS-1:0]   tokens;
    } result_group_t;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"))
            || (c == CHAR_UNDERSCORE);
    endfunction

    function automatic logic is_op(input logic [CHAR_W-1:0] c);
        return (c == "/") || (c == "=") || (c == "-") || (c == "+") || (c == "!")
            || (c == "*") || (c == "%") || (c == "<") || (c == ">") || (c == "&")
            || (c == "|") || (c == "^") || (c == "~") || (c == "?");
    endfunction

    function automatic logic is_punct(input logic [CHAR_W-1:0] c);
        return (c == "(") || (c == ")") || (c == "{") || (c == "}") || (c == "[")
            || (c == "]") || (c == CHAR_DOT) || (c == ",") || (c == ":")
            || (c == "@") || (c == "#");
    endfunction

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == CHAR_NUL) || (c == CHAR_TAB) || (c == CHAR_VT)
            || (c == CHAR_FF) || (c == CHAR_SPACE);
    endfunction

    function automatic logic [LEN_W-1:0] grow(input logic [LEN_W-1:0] len);
        return (len < LEN_W'(LEN_CAP)) ? len + LEN_W'(1) : len;
    endfunction

endpackage

// File: rtl/sct_scan.sv
// sct_scan: scanner state registers and the single-pass token logic that
// turns one transaction into up to three tokens. Depends on sct_pkg.
module sct_scan (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  logic [sct_pkg::CHAR_W-1:0]  char_code,
    input  logic                        end_of_input,
    output sct_pkg::result_group_t      group
);

    sct_pkg::scan_mode_t               mode_reg, mode_next;
    logic [sct_pkg::POS_W-1:0]         pend_start_reg, pend_start_next;
    logic [sct_pkg::LEN_W-1:0]         pend_len_reg, pend_len_next;
    logic [sct_pkg::CHAR_W-1:0]        pend_first_reg, pend_first_next;
    logic [sct_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [sct_pkg::LINE_W-1:0]        line_reg, line_next;
    logic                              acr_reg, acr_next;

    logic                              consumed;
    logic                              do_flush;
    logic [sct_pkg::RES_IDX_W-1:0]     flush_cnt;
    sct_pkg::token_kind_t              pend_kind;
    logic [sct_pkg::POS_W-1:0]         dot_pos;
    logic                              new_vld;
    sct_pkg::token_kind_t              new_kind;
    sct_pkg::token_t                   tok_pend, tok_dot, tok_new;

    always_comb begin
        mode_next       = mode_reg;
        pend_start_next = pend_start_reg;
        pend_len_next   = pend_len_reg;
        pend_first_next = pend_first_reg;
        pos_next        = pos_reg;
        line_next       = line_reg;
        acr_next        = 1'b0;
        consumed        = 1'b0;
        do_flush        = 1'b0;
        new_vld         = 1'b0;
        new_kind        = sct_pkg::KIND_BAD;

        if (end_of_input) begin
            do_flush  = 1'b1;
            mode_next = sct_pkg::MODE_IDLE;
        end else begin
            unique case (mode_reg)
                sct_pkg::MODE_WORD: begin
                    if (sct_pkg::is_letter(char_code) || sct_pkg::is_digit(char_code)) begin
                        pend_len_next = sct_pkg::grow(pend_len_reg);
                        consumed      = 1'b1;
                    end
                end
                sct_pkg::MODE_INT: begin
                    if (sct_pkg::is_digit(char_code)) begin
                        pend_len_next = sct_pkg::grow(pend_len_reg);
                        consumed      = 1'b1;
                    end else if (char_code == sct_pkg::CHAR_DOT) begin
                        mode_next = sct_pkg::MODE_DOT;
                        consumed  = 1'b1;
                    end
                end
                sct_pkg::MODE_DOT: begin
                    if (sct_pkg::is_digit(char_code)) begin
                        pend_len_next = sct_pkg::grow(sct_pkg::grow(pend_len_reg));
                        mode_next     = sct_pkg::MODE_FRAC;
                        consumed      = 1'b1;
                    end
                end
                sct_pkg::MODE_FRAC: begin
                    if (sct_pkg::is_digit(char_code)) begin
                        pend_len_next = sct_pkg::grow(pend_len_reg);
                        consumed      = 1'b1;
                    end
                end
                default: ;
            endcase

            if (!consumed) begin
                do_flush  = 1'b1;
                mode_next = sct_pkg::MODE_IDLE;
                priority if (char_code == sct_pkg::CHAR_CR) begin
                    if (line_reg != sct_pkg::LINE_MAX) line_next = line_reg + 1'b1;
                    acr_next = 1'b1;
                end else if (char_code == sct_pkg::CHAR_LF) begin
                    if (!acr_reg && (line_reg != sct_pkg::LINE_MAX)) begin
                        line_next = line_reg + 1'b1;
                    end
                end else if (sct_pkg::is_blank(char_code)) begin
                    // skipped
                end else if (sct_pkg::is_letter(char_code)) begin
                    mode_next       = sct_pkg::MODE_WORD;
                    pend_start_next = pos_reg;
                    pend_len_next   = sct_pkg::LEN_W'(1);
                    pend_first_next = char_code;
                end else if ((char_code >= "1") && (char_code <= "9")) begin
                    mode_next       = sct_pkg::MODE_INT;
                    pend_start_next = pos_reg;
                    pend_len_next   = sct_pkg::LEN_W'(1);
                    pend_first_next = char_code;
                end else if (sct_pkg::is_op(char_code)) begin
                    new_vld  = 1'b1;
                    new_kind = sct_pkg::KIND_OP;
                end else if (sct_pkg::is_punct(char_code)) begin
                    new_vld  = 1'b1;
                    new_kind = sct_pkg::KIND_PUNCT;
                end else begin
                    new_vld  = 1'b1;
                    new_kind = sct_pkg::KIND_BAD;
                end
            end

            if (pos_reg != sct_pkg::POS_MAX) pos_next = pos_reg + 1'b1;
        end
    end

    // pending token as flushed
    always_comb begin
        unique case (mode_reg)
            sct_pkg::MODE_WORD: begin
                pend_kind = sct_pkg::KIND_WORD;
                flush_cnt = sct_pkg::RES_IDX_W'(1);
            end
            sct_pkg::MODE_INT: begin
                pend_kind = sct_pkg::KIND_INT;
                flush_cnt = sct_pkg::RES_IDX_W'(1);
            end
            sct_pkg::MODE_DOT: begin
                pend_kind = sct_pkg::KIND_INT;
                flush_cnt = sct_pkg::RES_IDX_W'(2);
            end
            sct_pkg::MODE_FRAC: begin
                pend_kind = sct_pkg::KIND_FRAC;
                flush_cnt = sct_pkg::RES_IDX_W'(1);
            end
            default: begin
                pend_kind = sct_pkg::KIND_WORD;
                flush_cnt = '0;
            end
        endcase
    end

    assign dot_pos = (pos_reg != '0) ? pos_reg - 1'b1 : '0;

    always_comb begin
        tok_pend.token_kind   = pend_kind;
        tok_pend.token_start  = pend_start_reg;
        tok_pend.token_length = pend_len_reg;
        tok_pend.first_char   = pend_first_reg;
        tok_pend.line_number  = line_reg;

        tok_dot.token_kind    = sct_pkg::KIND_PUNCT;
        tok_dot.token_start   = dot_pos;
        tok_dot.token_length  = sct_pkg::LEN_W'(1);
        tok_dot.first_char    = sct_pkg::CHAR_DOT;
        tok_dot.line_number   = line_reg;

        tok_new.token_kind    = new_kind;
        tok_new.token_start   = pos_reg;
        tok_new.token_length  = sct_pkg::LEN_W'(1);
        tok_new.first_char    = char_code;
        tok_new.line_number   = line_reg;
    end

    always_comb begin
        logic [sct_pkg::RES_IDX_W-1:0] fc;
        fc = do_flush ? flush_cnt : '0;
        group.count     = fc + sct_pkg::RES_IDX_W'(new_vld);
        group.tokens[0] = (fc != '0) ? tok_pend : tok_new;
        group.tokens[1] = (fc == sct_pkg::RES_IDX_W'(2)) ? tok_dot : tok_new;
        group.tokens[2] = tok_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= sct_pkg::MODE_IDLE;
            pend_start_reg <= '0;
            pend_len_reg   <= '0;
            pend_first_reg <= '0;
            pos_reg        <= '0;
            line_reg       <= '0;
            acr_reg        <= 1'b0;
        end else if (accept) begin
            mode_reg       <= mode_next;
            pend_start_reg <= pend_start_next;
            pend_len_reg   <= pend_len_next;
            pend_first_reg <= pend_first_next;
            pos_reg        <= pos_next;
            line_reg       <= line_next;
            acr_reg        <= acr_next;
        end
    end

endmodule

// File: rtl/source_char_tokenizer_core.sv
// source_char_tokenizer_core: top level of the streaming tokenizer.
// Instantiates sct_scan and holds the token group queue. Depends on sct_pkg.
//
// Usage:
//   Slave channel: one source character per transaction in s_tdata[7:0];
//   s_tlast high marks end of text, which flushes any pending token and
//   carries no character (s_tdata is then ignored).
//   Master channel: one token per transaction in m_tdata; m_tlast marks the
//   final token caused by a given input transaction. A character may cause
//   zero, one, two or three tokens.
//   A character's tokens are written into the token group queue when it is
//   accepted and leave from the queue head. Throughput: one character per
//   cycle while each character gives at most one token and m_tready is
//   high; a character giving n tokens occupies the master side for n
//   transactions. The two-entry token group queue decouples the sides, so
//   a new character is taken while an earlier token still waits.
//   Receiver stall: tokens are held; once both queue entries hold tokens,
//   s_tready drops until the master side drains one entry.
//   Reset: aresetn low (synchronous) clears the scanner state, offset and
//   line count and empties the queue; no tokens are presented after it.
module source_char_tokenizer_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sct_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] char_code
    input  logic                           s_tlast,   // end_of_input
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] token_kind, [26:3] token_start, [34:27] token_length,
    // [42:35] first_char, [62:43] line_number, [63] zero
    output logic [sct_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast    // last
);

    logic                             s_fire, m_fire;
    logic                             push, pop, last_sub;
    sct_pkg::result_group_t           scan_group, head;
    sct_pkg::result_group_t           grp_mem [sct_pkg::GROUP_DEPTH];
    logic                             wr_ptr_reg, wr_ptr_next;
    logic                             rd_ptr_reg, rd_ptr_next;
    logic [sct_pkg::FILL_W-1:0]       fill_reg, fill_next;
    logic [sct_pkg::RES_IDX_W-1:0]    sub_reg, sub_next;

    sct_scan u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_fire),
        .char_code    (s_tdata[sct_pkg::CHAR_W-1:0]),
        .end_of_input (s_tlast),
        .group        (scan_group)
    );

    assign s_tready = (fill_reg != sct_pkg::FILL_W'(sct_pkg::GROUP_DEPTH));
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;

    assign head     = grp_mem[rd_ptr_reg];
    assign last_sub = (sub_reg == head.count - 1'b1);
    assign push     = s_fire && (scan_group.count != '0);
    assign pop      = m_fire && last_sub;

    assign m_tvalid = (fill_reg != '0);
    assign m_tdata  = sct_pkg::M_TDATA_W'(head.tokens[sub_reg]);
    assign m_tlast  = last_sub;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + sct_pkg::FILL_W'(push) - sct_pkg::FILL_W'(pop);
        sub_next    = sub_reg;
        if (m_fire) begin
            sub_next = last_sub ? '0 : sub_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            grp_mem[wr_ptr_reg] <= scan_group;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
            sub_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            sub_reg    <= sub_next;
        end
    end

endmodule

// File: rtl/sct_checker.sv
// sct_checker: port-level assertions for source_char_tokenizer_core,
// attached to the top level by the bind below. Depends on sct_pkg.
module sct_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sct_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tlast
);

    // stalled transaction stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("token changed while stalled");

    // kind code from the defined set
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= sct_pkg::KIND_BAD))
        else $error("undefined token kind");

    // every token covers at least one character
    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[34:27] != '0))
        else $error("zero length token");

    // nothing offered straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("token offered after reset");

endmodule

bind source_char_tokenizer_core sct_checker u_sct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: bench/tb_source_char_tokenizer_core.sv
// tb_source_char_tokenizer_core: self-checking bench for the streaming tokenizer.
// Drives characters on the slave stream, predicts every token and checks the
// master stream transaction by transaction. Depends on sct_pkg and the core.
`timescale 1ns / 100ps

module tb_source_char_tokenizer_core;
    import sct_pkg::*;

    localparam int DIR_ROWS     = 27;
    localparam int RANDOM_ITEMS = 400;
    localparam int IDLE_PCT     = 7;
    localparam int HOLD_AFTER   = 30;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_WORD    = 300;

    typedef enum {
        CC_ALPHA,
        CC_DIGIT,
        CC_SPACE,
        CC_OPER,
        CC_PUNC,
        CC_OTHER
    } char_class_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              eoi;
        logic              typed;
        token_kind_t       kind;
        logic [POS_W-1:0]  start;
    } stim_row_t;

    typedef struct {
        token_t tok;
        logic   last;
    } due_token_t;

    // typed rows: fresh after reset, extreme codes, unsupported characters, an operator and a punctuation mark
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{"0",        1'b0, 1'b1, KIND_BAD,   24'd0},
        '{8'hFF,      1'b0, 1'b1, KIND_BAD,   24'd1},
        '{"$",        1'b0, 1'b1, KIND_BAD,   24'd2},
        '{"/",        1'b0, 1'b1, KIND_OP,    24'd3},
        '{"#",        1'b0, 1'b1, KIND_PUNCT, 24'd4},
        '{"a",        1'b0, 1'b0, KIND_WORD,  24'd0},
        '{"_",        1'b0, 1'b0, KIND_WORD,  24'd0},
        '{"0",        1'b0, 1'b0, KIND_WORD,  24'd0},
        '{CHAR_TAB,   1'b0, 1'b0, KIND_WORD,  24'd0},
        '{"1",        1'b0, 1'b0, KIND_WORD,  24'd0},
        '{"0",        1'b0, 1'b0, KIND_WORD,  24'd0},
        '{CHAR_DOT,   1'b0, 1'b0, KIND_WORD,  24'd0},
        '{"-",        1'b0, 1'b0, KIND_WORD,  24'd0},
        '{"7",        1'b0, 1'b0, KIND_WORD,  24'd0},
        '{CHAR_DOT,   1'b0, 1'b0, KIND_WORD,  24'd0},
        '{"5",        1'b0, 1'b0, KIND_WORD,  24'd0},
        '{CHAR_DOT,   1'b0, 1'b0, KIND_WORD,  24'd0},
        '{CHAR_CR,    1'b0, 1'b0, KIND_WORD,  24'd0},
        '{CHAR_LF,    1'b0, 1'b0, KIND_WORD,  24'd0},
        '{"9",        1'b0, 1'b0, KIND_WORD,  24'd0},
        '{CHAR_LF,    1'b0, 1'b0, KIND_WORD,  24'd0},
        '{"3",        1'b0, 1'b0, KIND_WORD,  24'd0},
        '{CHAR_DOT,   1'b0, 1'b0, KIND_WORD,  24'd0},
        '{8'hA5,      1'b1, 1'b0, KIND_WORD,  24'd0},
        '{"Z",        1'b0, 1'b0, KIND_WORD,  24'd0},
        '{8'h00,      1'b1, 1'b0, KIND_WORD,  24'd0},
        '{8'h5A,      1'b1, 1'b0, KIND_WORD,  24'd0}
    };

    localparam logic [CHAR_W-1:0] BLANK_SET [5] = '{
        CHAR_NUL, CHAR_TAB, CHAR_VT, CHAR_FF, CHAR_SPACE
    };

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;   // [7:0] char_code
    logic                  s_tlast  = 1'b0; // end_of_input
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [2:0] token_kind, [26:3] token_start, [34:27] token_length,
    // [42:35] first_char, [62:43] line_number, [63] zero
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;         // last

    source_char_tokenizer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    string word_set  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string oper_set  = "/=-+!*%<>&|^~?";
    string punct_set = "(){}[].,:@#";

    // scanner state as predicted
    scan_mode_t        sc_mode  = MODE_IDLE;
    logic [POS_W-1:0]  sc_start = '0;
    logic [LEN_W-1:0]  sc_len   = '0;
    logic [CHAR_W-1:0] sc_first = '0;
    logic [POS_W-1:0]  sc_pos   = '0;
    logic [LINE_W-1:0] sc_line  = '0;
    logic              sc_cr    = 1'b0;

    token_t     step_tokens[$];
    due_token_t due_tokens[$];
    int         errors      = 0;
    int         tokens_seen = 0;
    int         item_cnt    = 0;
    int         quiet       = 0;
    logic       calm        = 1'b0;
    logic       held        = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic char_class_t classify(input logic [CHAR_W-1:0] c);
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CHAR_UNDERSCORE)
            return CC_ALPHA;
        if (c >= "0" && c <= "9")
            return CC_DIGIT;
        if (c == CHAR_NUL || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF
                || c == CHAR_SPACE)
            return CC_SPACE;
        case (c)
            "/", "=", "-", "+", "!", "*", "%", "<", ">", "&", "|", "^", "~", "?":
                return CC_OPER;
            "(", ")", "{", "}", "[", "]", ".", ",", ":", "@", "#":
                return CC_PUNC;
            default:
                return CC_OTHER;
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] lengthen(input logic [LEN_W-1:0] len);
        return (len < LEN_W'(LEN_CAP)) ? len + 1'b1 : len;
    endfunction

    function automatic void note(input token_kind_t kind, input logic [POS_W-1:0] start,
                                 input logic [LEN_W-1:0] len, input logic [CHAR_W-1:0] first);
        token_t t;
        t.token_kind   = kind;
        t.token_start  = start;
        t.token_length = len;
        t.first_char   = first;
        t.line_number  = sc_line;
        step_tokens.insert(step_tokens.size(), t);
    endfunction

    function automatic void close_pending(input logic [POS_W-1:0] pos);
        case (sc_mode)
            MODE_WORD: note(KIND_WORD, sc_start, sc_len, sc_first);
            MODE_INT:  note(KIND_INT, sc_start, sc_len, sc_first);
            MODE_DOT: begin
                note(KIND_INT, sc_start, sc_len, sc_first);
                note(KIND_PUNCT, (pos != 0) ? pos - 1'b1 : pos, 8'd1, CHAR_DOT);
            end
            MODE_FRAC: note(KIND_FRAC, sc_start, sc_len, sc_first);
            default: ;
        endcase
        sc_mode = MODE_IDLE;
    endfunction

    function automatic void open_pending(input scan_mode_t mode, input logic [CHAR_W-1:0] c);
        sc_mode  = mode;
        sc_start = sc_pos;
        sc_len   = 8'd1;
        sc_first = c;
    endfunction

    // tokens caused by one accepted transaction land in step_tokens
    function automatic void tokenize(input logic [CHAR_W-1:0] ch, input logic eoi);
        logic [POS_W-1:0] pos;
        logic             prev_cr;
        logic             taken;
        char_class_t      cls;
        pos = sc_pos;
        cls = classify(ch);
        step_tokens.delete();
        if (eoi) begin
            close_pending(pos);
            sc_cr = 1'b0;
        end else begin
            prev_cr = sc_cr;
            taken   = 1'b0;
            sc_cr   = 1'b0;
            case (sc_mode)
                MODE_WORD: if (cls == CC_ALPHA || cls == CC_DIGIT) begin
                    sc_len = lengthen(sc_len);
                    taken  = 1'b1;
                end
                MODE_INT: if (cls == CC_DIGIT) begin
                    sc_len = lengthen(sc_len);
                    taken  = 1'b1;
                end else if (ch == CHAR_DOT) begin
                    sc_mode = MODE_DOT;
                    taken   = 1'b1;
                end
                MODE_DOT: if (cls == CC_DIGIT) begin
                    sc_len  = lengthen(lengthen(sc_len));
                    sc_mode = MODE_FRAC;
                    taken   = 1'b1;
                end
                MODE_FRAC: if (cls == CC_DIGIT) begin
                    sc_len = lengthen(sc_len);
                    taken  = 1'b1;
                end
                default: ;
            endcase
            if (!taken) begin
                close_pending(pos);
                if (ch == CHAR_CR) begin
                    if (sc_line != LINE_MAX)
                        sc_line = sc_line + 1'b1;
                    sc_cr = 1'b1;
                end else if (ch == CHAR_LF) begin
                    if (!prev_cr && sc_line != LINE_MAX)
                        sc_line = sc_line + 1'b1;
                end else if (cls == CC_SPACE) begin
                end else if (cls == CC_ALPHA) begin
                    open_pending(MODE_WORD, ch);
                end else if (cls == CC_DIGIT && ch != "0") begin
                    open_pending(MODE_INT, ch);
                end else if (cls == CC_OPER) begin
                    note(KIND_OP, pos, 8'd1, ch);
                end else if (cls == CC_PUNC) begin
                    note(KIND_PUNCT, pos, 8'd1, ch);
                end else begin
                    note(KIND_BAD, pos, 8'd1, ch);
                end
            end
            if (sc_pos != POS_MAX)
                sc_pos = sc_pos + 1'b1;
        end
    endfunction

    task automatic push_char(input logic [CHAR_W-1:0] ch, input logic eoi,
                             input logic typed, input token_t typed_tok);
        due_token_t d;
        int         i;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= eoi;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        tokenize(ch, eoi);
        if (typed) begin
            step_tokens.delete();
            step_tokens.insert(0, typed_tok);
        end
        for (i = 0; i < step_tokens.size(); i++) begin
            d.tok  = step_tokens[i];
            d.last = (i == step_tokens.size() - 1);
            due_tokens.insert(due_tokens.size(), d);
        end
        item_cnt++;
    endtask

    task automatic compare_field(input string what, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // stimulus
    initial begin : source
        int        r;
        int        n;
        int        k;
        logic      long_done;
        stim_row_t row;
        token_t    want;
        long_done = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (r = 0; r < DIR_ROWS; r++) begin
            row                = DIRECTED[r];
            want.token_kind    = row.kind;
            want.token_start   = row.start;
            want.token_length  = 8'd1;
            want.first_char    = row.ch;
            want.line_number   = '0;
            push_char(row.ch, row.eoi, row.typed, want);
        end

        while (item_cnt < DIR_ROWS + RANDOM_ITEMS) begin
            calm <= (item_cnt >= 40 && item_cnt < 150);
            if (!long_done && item_cnt >= 100) begin
                // long enough to saturate the token length
                long_done = 1'b1;
                push_char("q", 1'b0, 1'b0, '0);
                for (k = 1; k < LONG_WORD; k++)
                    push_char(word_set[$urandom_range(0, word_set.len() - 1)],
                              1'b0, 1'b0, '0);
                push_char(CHAR_SPACE, 1'b0, 1'b0, '0);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    push_char(word_set[$urandom_range(0, 52)], 1'b0, 1'b0, '0);
                    n = $urandom_range(0, 7);
                    for (k = 0; k < n; k++)
                        push_char(word_set[$urandom_range(0, word_set.len() - 1)],
                                  1'b0, 1'b0, '0);
                end else if (r < 45) begin
                    push_char("1" + 8'($urandom_range(0, 8)), 1'b0, 1'b0, '0);
                    n = $urandom_range(0, 4);
                    for (k = 0; k < n; k++)
                        push_char("0" + 8'($urandom_range(0, 9)), 1'b0, 1'b0, '0);
                    if ($urandom_range(0, 1) == 1) begin
                        push_char(CHAR_DOT, 1'b0, 1'b0, '0);
                        if ($urandom_range(0, 9) < 7) begin
                            n = $urandom_range(1, 3);
                            for (k = 0; k < n; k++)
                                push_char("0" + 8'($urandom_range(0, 9)), 1'b0, 1'b0, '0);
                        end
                    end
                end else if (r < 57) begin
                    push_char(oper_set[$urandom_range(0, oper_set.len() - 1)],
                              1'b0, 1'b0, '0);
                end else if (r < 67) begin
                    push_char(punct_set[$urandom_range(0, punct_set.len() - 1)],
                              1'b0, 1'b0, '0);
                end else if (r < 77) begin
                    push_char(BLANK_SET[$urandom_range(0, 4)], 1'b0, 1'b0, '0);
                end else if (r < 85) begin
                    k = $urandom_range(0, 2);
                    if (k != 1)
                        push_char(CHAR_CR, 1'b0, 1'b0, '0);
                    if (k != 0)
                        push_char(CHAR_LF, 1'b0, 1'b0, '0);
                end else if (r < 93) begin
                    push_char(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
                end else if (r < 97) begin
                    push_char(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
                end else begin
                    push_char(($urandom_range(0, 1) == 1) ? CHAR_DOT : 8'h30,
                              1'b0, 1'b0, '0);
                end
            end
        end
        s_tvalid <= 1'b0;

        while (due_tokens.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver with random stalls and one long hold-off
    initial begin : sink
        int waited;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (!held && tokens_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                for (waited = 0; waited < HOLD_CYCLES; waited++)
                    @(posedge aclk);
            end
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin : check
        due_token_t d;
        token_t     got;
        if (aresetn && m_tvalid && m_tready) begin
            tokens_seen++;
            got = token_t'(m_tdata[M_TDATA_W-2:0]);
            if (due_tokens.size() == 0) begin
                errors++;
                $display("%0t: unexpected token, expected none, actual kind %0d start %0d",
                         $time, got.token_kind, got.token_start);
            end else begin
                d = due_tokens.pop_front();
                compare_field("token_kind", d.tok.token_kind, got.token_kind);
                compare_field("token_start", d.tok.token_start, got.token_start);
                compare_field("token_length", d.tok.token_length, got.token_length);
                compare_field("first_char", d.tok.first_char, got.first_char);
                compare_field("line_number", d.tok.line_number, got.line_number);
                compare_field("last", d.last, m_tlast);
                compare_field("tdata pad", 0, m_tdata[M_TDATA_W-1]);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

endmodule
